[src/gcchk_pkg.sv]
package gcchk_pkg;

    localparam int VTX_W = 6;
    localparam int VC_W  = 7;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CHECK  = 2'd2;

    localparam logic [VC_W-1:0] VC_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]       command;
        logic [VTX_W-1:0] src_vertex;
        logic [VTX_W-1:0] dst_vertex;
        logic             directed;
    } in_item_t;

    typedef struct packed {
        logic connected;
        logic bad_index;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic rd_src;
        logic wr_src;
        logic rd_dst;
        logic wr_dst;
        logic walk_init;
        logic pop;
        logic rd_top;
        logic expand;
        logic push;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic is_edge;
        logic is_check;
        logic bad;
        logic undirected;
        logic stack_empty;
        logic fresh_empty;
    } dp_stat_t;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_DECODE = 12'b0000_0000_0010,
        S_RD_SRC = 12'b0000_0000_0100,
        S_WR_SRC = 12'b0000_0000_1000,
        S_RD_DST = 12'b0000_0001_0000,
        S_WR_DST = 12'b0000_0010_0000,
        S_INIT   = 12'b0000_0100_0000,
        S_POP    = 12'b0000_1000_0000,
        S_TOP    = 12'b0001_0000_0000,
        S_EXPAND = 12'b0010_0000_0000,
        S_PUSH   = 12'b0100_0000_0000,
        S_FINISH = 12'b1000_0000_0000
    } state_t;

endpackage

[src/gcchk_ram.sv]
module gcchk_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/gcchk_ctrl.sv]
module gcchk_ctrl import gcchk_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd,
    output logic     busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_edge && !stat.bad)
                begin
                    state_next = S_RD_SRC;
                end
                else if (stat.is_check)
                begin
                    state_next = S_INIT;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_RD_SRC:
            begin
                cmd.rd_src = 1'b1;
                state_next = S_WR_SRC;
            end
            S_WR_SRC:
            begin
                cmd.wr_src = 1'b1;
                state_next = stat.undirected ? S_RD_DST : S_FINISH;
            end
            S_RD_DST:
            begin
                cmd.rd_dst = 1'b1;
                state_next = S_WR_DST;
            end
            S_WR_DST:
            begin
                cmd.wr_dst = 1'b1;
                state_next = S_FINISH;
            end
            S_INIT:
            begin
                cmd.walk_init = 1'b1;
                state_next    = S_POP;
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_TOP;
            end
            S_TOP:
            begin
                cmd.rd_top = 1'b1;
                state_next = S_EXPAND;
            end
            S_EXPAND:
            begin
                cmd.expand = 1'b1;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!stat.fresh_empty)
                begin
                    cmd.push = 1'b1;
                end
                else if (stat.stack_empty)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[src/gcchk_dp.sv]
module gcchk_dp import gcchk_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  in_item_t        request,
    input  logic            cfg_we,
    input  logic [VC_W-1:0] cfg_data,
    input  ctl_cmd_t        cmd,
    output dp_stat_t        stat,
    output out_item_t       result,
    output logic            done
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int DW = $clog2(MAX_VERTICES) + 1;

    in_item_t                item_reg;
    logic [VC_W-1:0]         vcount_reg;
    logic [MAX_VERTICES-1:0] row_valid_reg;
    logic                    rd_valid_reg;
    logic [MAX_VERTICES-1:0] reached_reg;
    logic [MAX_VERTICES-1:0] fresh_reg;
    logic [DW-1:0]           depth_reg;
    out_item_t               result_reg;
    logic                    done_reg;

    logic [VC_W-1:0]         live_n;
    logic [MAX_VERTICES-1:0] live_mask;
    logic                    is_edge;
    logic                    is_check;
    logic                    bad;
    logic [AW-1:0]           src_a;
    logic [AW-1:0]           dst_a;
    logic [AW-1:0]           adj_raddr;
    logic [AW-1:0]           adj_waddr;
    logic [AW-1:0]           bit_pos;
    logic                    adj_we;
    logic [MAX_VERTICES-1:0] adj_rdata;
    logic [MAX_VERTICES-1:0] row_in;
    logic [MAX_VERTICES-1:0] bit_sel;
    logic [MAX_VERTICES-1:0] row_out;
    logic [MAX_VERTICES-1:0] low_bit;
    logic [AW-1:0]           low_idx;
    logic [DW-1:0]           depth_m1;
    logic                    stk_we;
    logic [AW-1:0]           stk_waddr;
    logic [AW-1:0]           stk_wdata;
    logic [AW-1:0]           stk_rdata;

    // effective vertex count, clamped to 1 .. MAX_VERTICES
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            live_n = VC_W'(1);
        end
        else if (vcount_reg > VC_W'(MAX_VERTICES))
        begin
            live_n = VC_W'(MAX_VERTICES);
        end
        else
        begin
            live_n = vcount_reg;
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_VERTICES; k++)
        begin
            live_mask[k] = (VC_W'(k) < live_n);
        end
    end

    assign is_edge  = (item_reg.command == CMD_ADD) || (item_reg.command == CMD_REMOVE);
    assign is_check = (item_reg.command == CMD_CHECK);
    assign bad      = ({1'b0, item_reg.src_vertex} >= live_n)
                   || ({1'b0, item_reg.dst_vertex} >= live_n);
    assign src_a    = item_reg.src_vertex[AW-1:0];
    assign dst_a    = item_reg.dst_vertex[AW-1:0];

    // adjacency row access
    always_comb
    begin
        if (cmd.rd_top)
        begin
            adj_raddr = stk_rdata;
        end
        else if (cmd.rd_dst)
        begin
            adj_raddr = dst_a;
        end
        else
        begin
            adj_raddr = src_a;
        end
    end

    assign adj_we    = cmd.wr_src | cmd.wr_dst;
    assign adj_waddr = cmd.wr_dst ? dst_a : src_a;
    assign bit_pos   = cmd.wr_dst ? src_a : dst_a;
    assign row_in    = rd_valid_reg ? adj_rdata : '0;
    assign bit_sel   = MAX_VERTICES'(1) << bit_pos;
    assign row_out   = (item_reg.command == CMD_ADD) ? (row_in | bit_sel)
                                                     : (row_in & ~bit_sel);

    gcchk_ram #(
        .WIDTH (MAX_VERTICES),
        .DEPTH (MAX_VERTICES)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (row_out),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    // lowest fresh vertex
    assign low_bit = fresh_reg & (~fresh_reg + MAX_VERTICES'(1));

    always_comb
    begin
        low_idx = '0;
        for (int k = 0; k < MAX_VERTICES; k++)
        begin
            if (low_bit[k])
            begin
                low_idx = low_idx | AW'(k);
            end
        end
    end

    // walk stack
    assign depth_m1  = depth_reg - DW'(1);
    assign stk_we    = cmd.walk_init | cmd.push;
    assign stk_waddr = cmd.walk_init ? '0 : depth_reg[AW-1:0];
    assign stk_wdata = cmd.walk_init ? '0 : low_idx;

    gcchk_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_VERTICES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (depth_m1[AW-1:0]),
        .rdata (stk_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= request;
        end
        if (cmd.finish)
        begin
            result_reg.connected <= is_check && ((reached_reg & live_mask) == live_mask);
            result_reg.bad_index <= is_edge && bad;
        end
        if (cmd.expand)
        begin
            fresh_reg <= row_in & live_mask & ~reached_reg;
        end
        else if (cmd.push)
        begin
            fresh_reg <= fresh_reg & ~low_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VC_RESET;
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            reached_reg   <= '0;
            depth_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vcount_reg <= cfg_data;
            end
            if (adj_we)
            begin
                row_valid_reg[adj_waddr] <= 1'b1;
            end
            rd_valid_reg <= row_valid_reg[adj_raddr];
            if (cmd.walk_init)
            begin
                reached_reg <= MAX_VERTICES'(1);
                depth_reg   <= DW'(1);
            end
            else if (cmd.pop)
            begin
                depth_reg <= depth_m1;
            end
            else if (cmd.push)
            begin
                reached_reg <= reached_reg | low_bit;
                depth_reg   <= depth_reg + DW'(1);
            end
            done_reg <= cmd.finish;
        end
    end

    assign stat.is_edge     = is_edge;
    assign stat.is_check    = is_check;
    assign stat.bad         = bad;
    assign stat.undirected  = !item_reg.directed;
    assign stat.stack_empty = (depth_reg == '0);
    assign stat.fresh_empty = (fresh_reg == '0);

    assign result = result_reg;
    assign done   = done_reg;

endmodule

[src/graph_connectivity_check_core.sv]
// Graph connectivity checker. Issue a command by holding start high with the
// request fields while busy is low; it is taken at that clock edge. Exactly one
// result follows for every command: done is high for a single cycle with
// connected and bad_index valid, and the receiver cannot stall it, so capture
// it in that cycle. A new command may be issued in the same cycle as done.
// Adding or removing an edge updates the source row and, for an undirected
// edge, the destination row too, each row update being a read and a write of
// the single adjacency memory; an add or remove with an out-of-range vertex,
// or an unused code, goes straight to the result. A connectivity check walks
// the graph depth first: it pops a vertex, reads its row, takes the fresh
// vertices and pushes them one at a time. vertex_count is written through
// cfg_we / cfg_data and must only change while busy is low.
module graph_connectivity_check_core import gcchk_pkg::*; #(
    parameter int MAX_VERTICES = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  in_item_t        request,
    output logic            busy,
    output logic            done,
    output out_item_t       result,
    input  logic            cfg_we,
    input  logic [VC_W-1:0] cfg_data
);

    ctl_cmd_t ctl_cmd;
    dp_stat_t dp_stat;

    gcchk_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (dp_stat),
        .cmd   (ctl_cmd),
        .busy  (busy)
    );

    gcchk_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (ctl_cmd),
        .stat     (dp_stat),
        .result   (result),
        .done     (done)
    );

endmodule

[src/gcchk_checker.sv]
module gcchk_checker import gcchk_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_item_t result
);

    // a taken transaction keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> !busy)
        else $error("busy raised without a transaction");

    // every transaction ends with its result
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("transaction ended without a result");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.connected && result.bad_index))
        else $error("connected and bad_index both set");

endmodule

bind graph_connectivity_check_core gcchk_checker u_checker (.*);
